@@ rtl/core/cqa_pkg.sv @@
// types, constants and helpers shared by the cochran q accumulator
`default_nettype none
package cqa_pkg;

  localparam int MAX_VARS    = 16;
  localparam int VAR_W       = 4;
  localparam int K_W         = 5;
  localparam int WEIGHT_BITS = 16;
  localparam int CNT_W       = 40;
  localparam int CHS_W       = 24;
  localparam int ROW_W       = 64;
  localparam int S1_W        = 44;
  localparam int MUL_W       = 96;
  localparam int MULB_W      = 48;
  localparam int REM_W       = 112;
  localparam int Q_W         = 32;

  localparam logic [CNT_W-1:0] MAX40 = {CNT_W{1'b1}};
  localparam logic [CHS_W-1:0] MAX24 = {CHS_W{1'b1}};

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

  localparam logic REC_COUNTS = 1'b0;
  localparam logic REC_STAT   = 1'b1;

  localparam logic [0:0] REG_VAR_COUNT = 1'b0;

  typedef struct packed {
    logic [3:0]  var_index;
    logic [63:0] value_bits;
    logic        excluded;
    logic [15:0] case_weight;
    logic        case_end;
    logic        data_end;
  } item_t;

  typedef struct packed {
    logic        record_kind;
    logic [3:0]  out_var;
    logic [39:0] hit_total;
    logic [39:0] miss_total;
    logic [39:0] case_total;
    logic [31:0] q_value;
    logic [3:0]  degrees;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_UPD, S_SQ, S_MULW, S_ADDR, S_ENDSEL, S_EMIT, S_HSQ, S_S1LD,
    S_S1SQ, S_KS1, S_CHK, S_NUM1, S_NUM2, S_NUM3, S_SAT, S_DIV, S_STAT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_UPD, OP_SQ, OP_MULW, OP_ADDR, OP_ENDSEL, OP_EMIT, OP_HSQ,
    OP_S1LD, OP_S1SQ, OP_KS1, OP_CHK, OP_NUM1, OP_NUM2, OP_NUM3, OP_SAT,
    OP_DIV, OP_STAT
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic dend;
    logic tmv;
    logic mul_done;
    logic last_var;
    logic zero_den;
    logic sat;
    logic div_last;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat40(input logic [CNT_W:0] s);
    return s[CNT_W] ? MAX40 : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cqa_ctrl.sv @@
// sequencer for item updates and the end of data pass
`default_nettype none
module cqa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cqa_pkg::sts_t sts_i,
  output cqa_pkg::cmd_t      cmd_o,
  output logic               busy_o
);
  import cqa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_UPD;
      S_UPD: begin
        if (sts_i.close) state_d = S_SQ;
        else if (sts_i.dend) state_d = S_ENDSEL;
        else state_d = S_IDLE;
      end
      S_SQ:     state_d = S_MULW;
      S_MULW:   state_d = S_ADDR;
      S_ADDR:   state_d = sts_i.dend ? S_ENDSEL : S_IDLE;
      S_ENDSEL: state_d = sts_i.tmv ? S_STAT : S_EMIT;
      S_EMIT:   state_d = S_HSQ;
      S_HSQ: begin
        if (sts_i.mul_done) state_d = sts_i.last_var ? S_S1LD : S_EMIT;
      end
      S_S1LD:   state_d = S_S1SQ;
      S_S1SQ:   if (sts_i.mul_done) state_d = S_KS1;
      S_KS1:    state_d = S_CHK;
      S_CHK:    state_d = sts_i.zero_den ? S_STAT : S_NUM1;
      S_NUM1:   state_d = S_NUM2;
      S_NUM2:   state_d = S_NUM3;
      S_NUM3:   state_d = S_SAT;
      S_SAT:    state_d = sts_i.sat ? S_STAT : S_DIV;
      S_DIV:    if (sts_i.div_last) state_d = S_STAT;
      S_STAT:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o     = (state_q != S_IDLE);
    cmd_o.load = (state_q == S_IDLE) && start_i;
    case (state_q)
      S_UPD:    cmd_o.op = OP_UPD;
      S_SQ:     cmd_o.op = OP_SQ;
      S_MULW:   cmd_o.op = OP_MULW;
      S_ADDR:   cmd_o.op = OP_ADDR;
      S_ENDSEL: cmd_o.op = OP_ENDSEL;
      S_EMIT:   cmd_o.op = OP_EMIT;
      S_HSQ:    cmd_o.op = OP_HSQ;
      S_S1LD:   cmd_o.op = OP_S1LD;
      S_S1SQ:   cmd_o.op = OP_S1SQ;
      S_KS1:    cmd_o.op = OP_KS1;
      S_CHK:    cmd_o.op = OP_CHK;
      S_NUM1:   cmd_o.op = OP_NUM1;
      S_NUM2:   cmd_o.op = OP_NUM2;
      S_NUM3:   cmd_o.op = OP_NUM3;
      S_SAT:    cmd_o.op = OP_SAT;
      S_DIV:    cmd_o.op = OP_DIV;
      S_STAT:   cmd_o.op = OP_STAT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/cqa_dpath.sv @@
// counters, shift-add multiplier, divider and result register
`default_nettype none
module cqa_dpath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cqa_pkg::cmd_t   cmd_i,
  input  wire cqa_pkg::item_t  item_i,
  input  wire logic [4:0]      var_count_i,
  output cqa_pkg::sts_t        sts_o,
  output cqa_pkg::result_t     result_o,
  output logic                 result_valid_o
);
  import cqa_pkg::*;

  item_t            it_q;
  logic             sk_q, fk_q, tmv_q, zden_q;
  logic [63:0]      sc_q, fc_q;
  logic [CNT_W-1:0] hit_q  [MAX_VARS];
  logic [CNT_W-1:0] miss_q [MAX_VARS];
  logic [CHS_W-1:0] chs_q;
  logic [ROW_W-1:0] row_q;
  logic [CNT_W-1:0] ws_q;
  logic [47:0]      sq_q;
  logic [63:0]      t_q;
  logic [VAR_W-1:0] vi_q;
  logic [S1_W-1:0]  s1_q;
  logic [MUL_W-1:0] s2_q, s1sq_q, num_q;
  logic [MUL_W-1:0] ma_q, acc_q;
  logic [MULB_W-1:0] mb_q;
  logic [ROW_W-1:0] ks1_q, den_q;
  logic [REM_W-1:0] rem_q, dsh_q;
  logic [4:0]       bit_q;
  logic [Q_W-1:0]   q_q;
  result_t          res_q;
  logic             res_valid_q;

  logic [K_W-1:0]   k;
  logic [VAR_W-1:0] km1;
  logic             in_range, use_val, match_s, match_f, new_fail;
  logic             is_hit, is_miss, third, tmv_d;
  logic [VAR_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_h, rd_m;
  logic [ROW_W:0]   row_sum;
  logic [REM_W-1:0] lim;

  always_comb begin
    if (var_count_i < K_W'(2)) k = K_W'(2);
    else if (var_count_i > K_W'(MAX_VARS)) k = K_W'(MAX_VARS);
    else k = var_count_i;
    km1 = VAR_W'(k - K_W'(1));
  end

  // classification of the latched item against the two known codes
  always_comb begin
    in_range = ({1'b0, it_q.var_index} < k);
    use_val  = !tmv_q && !it_q.excluded && in_range;
    match_s  = sk_q ? (it_q.value_bits == sc_q) : 1'b1;
    new_fail = sk_q && !fk_q && (it_q.value_bits != sc_q);
    match_f  = fk_q ? (it_q.value_bits == fc_q) : new_fail;
    is_hit   = use_val && match_s;
    is_miss  = use_val && !match_s && match_f;
    third    = use_val && !match_s && !match_f;
    tmv_d    = tmv_q || third;
  end

  assign rd_idx  = (cmd_i.op == OP_UPD) ? it_q.var_index : vi_q;
  assign rd_h    = hit_q[rd_idx];
  assign rd_m    = miss_q[rd_idx];
  assign row_sum = {1'b0, row_q} + {1'b0, t_q};
  assign lim     = {16'd0, den_q, 32'd0};

  always_comb begin
    sts_o.close    = (it_q.case_end || it_q.data_end) && !tmv_d;
    sts_o.dend     = it_q.data_end;
    sts_o.tmv      = tmv_q;
    sts_o.mul_done = (mb_q == '0);
    sts_o.last_var = ({1'b0, vi_q} == km1 + K_W'(0));
    sts_o.zero_den = (ks1_q <= row_q);
    sts_o.sat      = (rem_q >= lim);
    sts_o.div_last = (bit_q == 5'd0);
  end

  // accumulation state, cleared by reset and after each data end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_q   <= 1'b0;
      fk_q   <= 1'b0;
      tmv_q  <= 1'b0;
      zden_q <= 1'b0;
      chs_q  <= '0;
      row_q  <= '0;
      ws_q   <= '0;
      for (int i = 0; i < MAX_VARS; i++) begin
        hit_q[i]  <= '0;
        miss_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_UPD: begin
          if (use_val && !sk_q) sk_q <= 1'b1;
          if (use_val && new_fail) fk_q <= 1'b1;
          tmv_q <= tmv_d;
          if (is_hit) begin
            hit_q[rd_idx] <= sat40({1'b0, rd_h} + (CNT_W+1)'(it_q.case_weight));
            if (chs_q != MAX24) chs_q <= chs_q + CHS_W'(1);
          end
          if (is_miss) begin
            miss_q[rd_idx] <= sat40({1'b0, rd_m} + (CNT_W+1)'(it_q.case_weight));
          end
        end
        OP_ADDR: begin
          row_q <= row_sum[ROW_W] ? {ROW_W{1'b1}} : row_sum[ROW_W-1:0];
          ws_q  <= sat40({1'b0, ws_q} + (CNT_W+1)'(it_q.case_weight));
          chs_q <= '0;
        end
        OP_ENDSEL: zden_q <= 1'b0;
        OP_CHK:    zden_q <= sts_o.zero_den;
        OP_STAT: begin
          sk_q   <= 1'b0;
          fk_q   <= 1'b0;
          tmv_q  <= 1'b0;
          chs_q  <= '0;
          row_q  <= '0;
          ws_q   <= '0;
          for (int i = 0; i < MAX_VARS; i++) begin
            hit_q[i]  <= '0;
            miss_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    case (cmd_i.op)
      OP_UPD: begin
        if (use_val && !sk_q) sc_q <= it_q.value_bits;
        if (use_val && new_fail) fc_q <= it_q.value_bits;
      end
      OP_SQ:   sq_q <= chs_q * chs_q;
      OP_MULW: t_q  <= sq_q * it_q.case_weight;
      OP_ENDSEL: begin
        s1_q <= '0;
        s2_q <= '0;
        vi_q <= '0;
      end
      OP_EMIT: begin
        s1_q  <= s1_q + S1_W'(rd_h);
        ma_q  <= MUL_W'(rd_h);
        mb_q  <= MULB_W'(rd_h);
        acc_q <= '0;
      end
      OP_HSQ: begin
        if (mb_q == '0) begin
          s2_q <= s2_q + acc_q;
          vi_q <= vi_q + VAR_W'(1);
        end else begin
          if (mb_q[0]) acc_q <= acc_q + ma_q;
          ma_q <= ma_q << 1;
          mb_q <= mb_q >> 1;
        end
      end
      OP_S1LD: begin
        ma_q  <= MUL_W'(s1_q);
        mb_q  <= MULB_W'(s1_q);
        acc_q <= '0;
      end
      OP_S1SQ: begin
        if (mb_q == '0) begin
          s1sq_q <= acc_q;
        end else begin
          if (mb_q[0]) acc_q <= acc_q + ma_q;
          ma_q <= ma_q << 1;
          mb_q <= mb_q >> 1;
        end
      end
      OP_KS1:  ks1_q <= ROW_W'(s1_q) * k;
      OP_CHK:  den_q <= ks1_q - row_q;
      OP_NUM1: num_q <= s2_q * k;
      OP_NUM2: num_q <= (num_q >= s1sq_q) ? (num_q - s1sq_q) : '0;
      OP_NUM3: rem_q <= {num_q * km1, 16'd0};
      OP_SAT: begin
        q_q   <= sts_o.sat ? {Q_W{1'b1}} : '0;
        dsh_q <= {17'd0, den_q, 31'd0};
        bit_q <= 5'd31;
      end
      OP_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q      <= rem_q - dsh_q;
          q_q[bit_q] <= 1'b1;
        end
        dsh_q <= dsh_q >> 1;
        bit_q <= bit_q - 5'd1;
      end
      default: ;
    endcase
  end

  // result register, one strobe per record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.op == OP_EMIT) || (cmd_i.op == OP_STAT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      res_q             <= '0;
      res_q.record_kind <= REC_COUNTS;
      res_q.out_var     <= vi_q;
      res_q.hit_total   <= rd_h;
      res_q.miss_total  <= rd_m;
    end else if (cmd_i.op == OP_STAT) begin
      res_q             <= '0;
      res_q.record_kind <= REC_STAT;
      res_q.case_total  <= ws_q;
      res_q.degrees     <= km1;
      res_q.last        <= 1'b1;
      if (tmv_q) begin
        res_q.status <= STATUS_TOO_MANY;
      end else if (zden_q) begin
        res_q.status <= STATUS_ZERO_DEN;
      end else begin
        res_q.status  <= STATUS_OK;
        res_q.q_value <= q_q;
      end
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/cochran_q_accumulator.sv @@
// top level of the cochran q accumulator: register port and core
//
// Items enter on item_i, taken at a clock edge where start_i is high and
// busy_o is low. One item at a time is worked on: an item that closes no
// case is handled in the update state alone, one that closes a case also
// in the hit square, weight product and saturating row-sum add states.
// An item with data_end starts the end pass: per variable one count
// record, then the hit square by a shift-add multiplier; then the square
// of the hit sum, setup and a restoring division for the 32-bit Q, and
// the statistic record, which after a third distinct value comes alone.
// Records appear on result_o for one cycle each with result_valid_o,
// registered in the cycle after the state that forms them; the receiver
// cannot stall them and the statistic record (last set) is always the
// final one. var_count is written over APB at addresses 0 to 3; the user
// must write it only while idle, which the block does not enforce.
// Reset clears all counters and sets var_count to 2; no clearing pass.
`default_nettype none
module cochran_q_accumulator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire cqa_pkg::item_t   item_i,
  output logic                  busy_o,
  output cqa_pkg::result_t      result_o,
  output logic                  result_valid_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import cqa_pkg::*;

  logic [4:0] var_count_q;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= 5'd2;
    end else if (psel && penable && pwrite && (paddr[2] == REG_VAR_COUNT)) begin
      var_count_q <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VAR_COUNT) ? {27'd0, var_count_q} : 32'd0;

  cqa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  cqa_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .var_count_i    (var_count_q),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/cqa_checker.sv @@
// port-level checks for the cochran q accumulator and their bind
`default_nettype none
module cqa_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             result_valid_o,
  input wire cqa_pkg::result_t result_o
);
  import cqa_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after an item was taken");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result appeared with no item in work");

  a_last_is_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.last == (result_o.record_kind == REC_STAT)))
    else $error("last flag does not match the statistic record");

  a_stat_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("record followed the final record");

endmodule

bind cochran_q_accumulator cqa_checker u_cqa_checker (.*);
`default_nettype wire

@@ verif/cqa_checker.sv @@
// checker for the cochran q accumulator: predicts records and compares them
module cqa_tb_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_o,
  input  cqa_pkg::item_t        item_i,
  input  logic                  result_valid_o,
  input  cqa_pkg::result_t      result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cqa_pkg::*;

  logic [4:0]  var_count;
  logic        succ_known, fail_known, overflowed;
  logic [63:0] succ_code, fail_code;
  logic [39:0] hits [MAX_VARS];
  logic [39:0] misses [MAX_VARS];
  logic [23:0] open_hits;
  logic [63:0] row_sq;
  logic [39:0] weight_total;
  result_t     expected_records[$];

  assign pending_count = expected_records.size();

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [39:0] add_sat40(input logic [39:0] a, input logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? MAX40 : s[39:0];
  endfunction

  task automatic clear_tallies();
    succ_known = 0; fail_known = 0; overflowed = 0;
    succ_code = '0; fail_code = '0;
    for (int v = 0; v < MAX_VARS; v++) begin
      hits[v] = '0; misses[v] = '0;
    end
    open_hits = '0; row_sq = '0; weight_total = '0;
  endtask

  task automatic close_case(input logic [15:0] w);
    logic [127:0] t;
    logic [64:0]  s;
    t = 128'(w) * (128'(open_hits) * 128'(open_hits));
    weight_total = add_sat40(weight_total, 40'(w));
    s = {1'b0, row_sq} + {1'b0, t[63:0]};
    row_sq = (t[127:64] != 0 || s[64]) ? '1 : s[63:0];
    open_hits = '0;
  endtask

  function automatic logic [31:0] q_stat(input int k, output logic [1:0] st);
    logic [63:0]  s1, ks1, den;
    logic [127:0] s2, num, sq1;
    s1 = '0; s2 = '0;
    for (int v = 0; v < k; v++) begin
      s1 += 64'(hits[v]);
      s2 += 128'(hits[v]) * 128'(hits[v]);
    end
    ks1 = s1 * 64'(k);
    if (ks1 <= row_sq) begin
      st = STATUS_ZERO_DEN;
      return '0;
    end
    st = STATUS_OK;
    den = ks1 - row_sq;
    num = s2 * 128'(k);
    sq1 = 128'(s1) * 128'(s1);
    num = (num < sq1) ? '0 : num - sq1;
    num = (num * 128'(k - 1)) << 16;
    if (num >= (128'(den) << 32)) return '1;
    return 32'(num / 128'(den));
  endfunction

  task automatic predict_item(input item_t it);
    int         k;
    logic [1:0] st;
    result_t    r;
    k = (var_count < 2) ? 2 : (var_count > MAX_VARS) ? MAX_VARS : int'(var_count);
    if (!overflowed && !it.excluded && int'(it.var_index) < k) begin
      if (!succ_known) begin
        succ_known = 1; succ_code = it.value_bits;
      end else if (!fail_known && it.value_bits != succ_code) begin
        fail_known = 1; fail_code = it.value_bits;
      end
      if (it.value_bits == succ_code) begin
        hits[it.var_index] = add_sat40(hits[it.var_index], 40'(it.case_weight));
        if (open_hits != MAX24) open_hits++;
      end else if (fail_known && it.value_bits == fail_code) begin
        misses[it.var_index] = add_sat40(misses[it.var_index], 40'(it.case_weight));
      end else begin
        overflowed = 1;
      end
    end
    if ((it.case_end || it.data_end) && !overflowed) close_case(it.case_weight);
    if (!it.data_end) return;
    st = STATUS_TOO_MANY;
    r = '0;
    if (!overflowed) begin
      for (int v = 0; v < k; v++) begin
        r = '0;
        r.record_kind = REC_COUNTS;
        r.out_var = 4'(v);
        r.hit_total = hits[v];
        r.miss_total = misses[v];
        expected_records.push_back(r);
      end
      r = '0;
      r.q_value = q_stat(k, st);
      if (st != STATUS_OK) r.q_value = '0;
    end
    r.record_kind = REC_STAT;
    r.case_total = weight_total;
    r.degrees = 4'(k - 1);
    r.status = st;
    r.last = 1'b1;
    expected_records.push_back(r);
    clear_tallies();
  endtask

  initial begin
    fail_count = 0;
    var_count = 5'd2;
    clear_tallies();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == 3'({REG_VAR_COUNT, 2'b00}))
        var_count <= pwdata[4:0];
      if (start_i && !busy_o) predict_item(item_i);
      if (result_valid_o) begin
        if (expected_records.size() == 0) begin
          report("unexpected record", 128'(result_o), '0);
        end else begin
          result_t e;
          e = expected_records.pop_front();
          if (result_o.record_kind !== e.record_kind)
            report("record_kind", 128'(result_o.record_kind), 128'(e.record_kind));
          if (result_o.out_var !== e.out_var)
            report("out_var", 128'(result_o.out_var), 128'(e.out_var));
          if (result_o.hit_total !== e.hit_total)
            report("hit_total", 128'(result_o.hit_total), 128'(e.hit_total));
          if (result_o.miss_total !== e.miss_total)
            report("miss_total", 128'(result_o.miss_total), 128'(e.miss_total));
          if (result_o.case_total !== e.case_total)
            report("case_total", 128'(result_o.case_total), 128'(e.case_total));
          if (result_o.q_value !== e.q_value)
            report("q_value", 128'(result_o.q_value), 128'(e.q_value));
          if (result_o.degrees !== e.degrees)
            report("degrees", 128'(result_o.degrees), 128'(e.degrees));
          if (result_o.status !== e.status)
            report("status", 128'(result_o.status), 128'(e.status));
          if (result_o.last !== e.last)
            report("last", 128'(result_o.last), 128'(e.last));
        end
      end
    end
  end

  final begin
    if (expected_records.size() != 0) $display("records still outstanding: %0d",
                                                expected_records.size());
  end
endmodule

@@ verif/testbench.sv @@
// testbench top for the cochran q accumulator: stimulus, register writes, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cqa_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  item_t       item_i = '0;
  logic        busy_o, result_valid_o;
  result_t     result_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending_count;
  logic        quiet;
  int          cur_k;
  logic [63:0] code_a, code_b;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  cochran_q_accumulator u_top (.*);

  cqa_tb_checker u_checker (.*);

  initial begin
    #50ms;
    $display("cochran_q_accumulator regression: fail");
    $finish;
  end

  // start is driven directly so that back to back items never stack two updates
  task automatic send(input item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 11) @(negedge clk_i);
    end
    start_i = 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // let the end pass finish before touching the register
  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_count != 0 || busy_o) && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_var_count(input logic [4:0] k);
    drain();
    psel <= 1; pwrite <= 1; paddr <= 3'({REG_VAR_COUNT, 2'b00}); pwdata <= 32'(k);
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    cur_k = (k < 2) ? 2 : (k > 16) ? 16 : int'(k);
  endtask

  function automatic item_t make_item(input logic [3:0] v, input logic [63:0] val,
                                      input logic ex, input logic [15:0] w,
                                      input logic ce, input logic de);
    item_t it;
    it.var_index = v; it.value_bits = val; it.excluded = ex;
    it.case_weight = w; it.case_end = ce; it.data_end = de;
    return it;
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(3))
      0: return 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // one data set of the given number of cases over the active variables, optionally with third values
  task automatic send_data_set(input int cases, input bit third_value);
    logic [15:0] w;
    logic [63:0] val;
    for (int c = 0; c < cases; c++) begin
      w = rand_weight();
      for (int v = 0; v < cur_k; v++) begin
        val = $urandom_range(1) ? code_a : code_b;
        if (third_value && $urandom_range(19) == 0) val = {$urandom, $urandom};
        send(make_item(4'(v), val, $urandom_range(15) == 0, w, v == cur_k - 1,
                       c == cases - 1 && v == cur_k - 1));
      end
    end
  endtask

  initial begin
    int sent;
    quiet = 0;
    cur_k = 2;
    code_a = 64'h0; code_b = '1;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: reset k of 2, extreme codes and weights
    send(make_item(0, 64'h0, 0, 16'hFFFF, 0, 0));
    send(make_item(1, '1, 0, 16'hFFFF, 1, 0));
    send(make_item(0, '1, 0, 16'd0, 0, 0));
    send(make_item(1, '1, 1, 16'd1, 1, 0));
    send(make_item(15, 64'h0, 0, 16'd7, 0, 0));  // out of range variable
    send(make_item(0, 64'h0, 0, 16'd3, 0, 1));   // data end closes open case
    // all hits only: zero denominator
    send(make_item(0, 64'h5, 0, 16'd1, 0, 0));
    send(make_item(1, 64'h5, 0, 16'd1, 1, 1));
    // third distinct value
    send(make_item(0, 64'h1, 0, 16'd1, 0, 0));
    send(make_item(1, 64'h2, 0, 16'd1, 1, 0));
    send(make_item(0, 64'h3, 0, 16'd1, 0, 0));
    send(make_item(1, 64'h1, 0, 16'd1, 1, 1));
    // all excluded data set
    send(make_item(0, 64'h9, 1, 16'd1, 0, 0));
    send(make_item(1, 64'h9, 1, 16'd1, 0, 1));

    write_var_count(5'd16);
    code_a = 64'hAAAA_5555_0F0F_F0F0; code_b = 64'h5555_AAAA_F0F0_0F0F;
    send_data_set(2, 0);
    write_var_count(5'd0);   // clamps to two
    send_data_set(3, 0);
    write_var_count(5'd31);  // clamps to sixteen
    send_data_set(1, 0);

    // random: mostly well-formed sets, some noise and broken sets
    sent = 0;
    while (sent < 400) begin
      if ($urandom_range(5) == 0) write_var_count(5'($urandom_range(31)));
      code_a = {$urandom, $urandom};
      code_b = $urandom_range(3) == 0 ? ~code_a : {$urandom, $urandom};
      quiet = (sent > 150 && sent < 230);
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 6))
          send(make_item(4'($urandom), $urandom_range(1) ? code_a : {$urandom, $urandom},
                         1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)),
                         $urandom_range(9) == 0));
        sent += 4;
      end else begin
        int n;
        n = $urandom_range(1, 4);
        send_data_set(n, $urandom_range(3) == 0);
        sent += n * cur_k;
      end
      if ($urandom_range(9) == 0) drain();
    end
    send(make_item(0, code_a, 0, 16'd1, 1, 1));
    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("cochran_q_accumulator regression: pass");
    end else begin
      $display("cochran_q_accumulator regression: fail");
    end
    $finish;
  end
endmodule
